[sv/rie_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the row index bitvector encoder
// no dependencies; imported by every other file of the block
package rie_pkg;

  // stream and word geometry
  localparam int WORD_BITS  = 32;
  localparam int INDEX_BITS = 32;
  localparam int POS_BITS   = $clog2(WORD_BITS);
  localparam int CNT_BITS   = POS_BITS + 1;
  localparam int RANK_BITS  = 32;
  localparam int WNUM_BITS  = 27;

  // result queue geometry
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  // one finished word
  typedef struct packed {
    logic [WORD_BITS-1:0] bit_word;
    logic [RANK_BITS-1:0] rank_before;
    logic [WNUM_BITS-1:0] word_number;
    logic                 gap_seen;
    logic                 end_of_run;
  } word_res_t;

  // results pushed by the front end in one cycle (zero, one or two)
  typedef struct packed {
    logic [1:0] num;
    word_res_t  res0;
    word_res_t  res1;
  } push_t;

  // front end status, for checking
  typedef struct packed {
    logic                have_prev;
    logic [POS_BITS-1:0] bit_pos;
  } front_stat_t;

endpackage

[sv/rie_in_if.sv]
`timescale 1ns / 1ps
// input channel of the encoder: valid/ready with one row index per transaction
// depends on rie_pkg
interface rie_in_if;
  logic                             valid;
  logic                             ready;
  logic [rie_pkg::INDEX_BITS-1:0]   row_index;
  logic                             is_final;

  modport source (output valid, output row_index, output is_final, input ready);
  modport sink   (input valid, input row_index, input is_final, output ready);
endinterface

[sv/rie_out_if.sv]
`timescale 1ns / 1ps
// result channel of the encoder: valid/ready with one finished word per transaction
// depends on rie_pkg
interface rie_out_if;
  logic                            valid;
  logic                            ready;
  logic [rie_pkg::WORD_BITS-1:0]   bit_word;
  logic [rie_pkg::RANK_BITS-1:0]   rank_before;
  logic [rie_pkg::WNUM_BITS-1:0]   word_number;
  logic                            gap_seen;
  logic                            end_of_run;

  modport source (output valid, output bit_word, output rank_before, output word_number,
                  output gap_seen, output end_of_run, input ready);
  modport sink   (input valid, input bit_word, input rank_before, input word_number,
                  input gap_seen, input end_of_run, output ready);
endinterface

[sv/row_index_bitvector_encoder.sv]
`timescale 1ns / 1ps
// top level of the row index bitvector encoder with rank directory
// depends on rie_pkg, rie_in_if, rie_out_if, rie_front, rie_queue, rie_back
//
// usage:
//   in_ch takes one nondecreasing row index per transaction, is_final marks
//   the last element of a stream. out_ch gives one transaction per finished
//   32-bit word: the packed row-change bits, the count of set bits in all
//   earlier words, the word number, a flag for index steps larger than one
//   and an end-of-run flag on the stream's final word.
//   throughput: one input transaction per cycle; the front end compares and
//   packs combinationally and the output register sends one word a cycle.
//   an element that both closes a full word and ends the stream makes two
//   words, which sit in a four-entry queue; input is held off only while
//   fewer than two queue entries are free.
//   a word is written to the queue at the edge that accepts the transaction
//   finishing it and is loaded into the output register, which raises
//   out_ch.valid, once that register is empty or being taken.
//   reset (rst_n low, synchronous) clears the stream state, empties the
//   queue and drops out_ch.valid. a stalled receiver holds the output
//   register; the queue then fills and in_ch.ready falls.
module row_index_bitvector_encoder (
  input  logic      clk,
  input  logic      rst_n,
  rie_in_if.sink    in_ch,
  rie_out_if.source out_ch
);
  import rie_pkg::*;

  push_t                push;
  front_stat_t          fstat;
  word_res_t            head;
  logic                 room, head_valid, pop, take;
  logic [QCNT_BITS-1:0] q_count;

  // input transaction handshake
  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;

  rie_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .row_index_i (in_ch.row_index),
    .is_final_i  (in_ch.is_final),
    .push_o      (push),
    .stat_o      (fstat)
  );

  rie_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop),
    .count_o      (q_count)
  );

  rie_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_BITS'(QDEPTH))
    else $error("result queue overfilled");

  // the last element of a stream clears the stream state
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.is_final |=> !fstat.have_prev && (fstat.bit_pos == '0))
    else $error("stream state not cleared after final element");

  // a full word restarts the bit position
  a_word_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_ch.is_final && fstat.have_prev &&
    (fstat.bit_pos == POS_BITS'(WORD_BITS - 1)) |=> fstat.bit_pos == '0)
    else $error("bit position did not wrap at word end");

  // a gap flag always comes with at least one set bit
  a_gap_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.gap_seen |-> out_ch.bit_word != '0)
    else $error("gap flag on a word without set bits");

endmodule

[sv/rie_front.sv]
`timescale 1ns / 1ps
// front end: compares each index with the previous one, packs the bits and
// builds finished words; depends on rie_pkg
module rie_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take_i,
  input  logic [rie_pkg::INDEX_BITS-1:0] row_index_i,
  input  logic                           is_final_i,
  output rie_pkg::push_t                 push_o,
  output rie_pkg::front_stat_t           stat_o
);
  import rie_pkg::*;

  logic [INDEX_BITS-1:0] prev_r, prev_nxt;
  logic                  have_r, have_nxt;
  logic [WORD_BITS-1:0]  acc_r, acc_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [WNUM_BITS-1:0]  wnum_r, wnum_nxt;
  logic [RANK_BITS-1:0]  rank_r, rank_nxt;
  logic                  gap_r, gap_nxt;

  logic [INDEX_BITS-1:0] diff;
  logic                  bit_set, big_step, word_full;
  logic [WORD_BITS-1:0]  acc_a, acc_b;
  logic [CNT_BITS-1:0]   cnt_a, cnt_b;
  logic                  gap_a, gap_b;
  logic [POS_BITS-1:0]   pos_b;
  logic [WNUM_BITS-1:0]  wnum_b;
  logic [RANK_BITS-1:0]  rank_b;
  word_res_t             res_full, res_last;

  // compare with the previous element
  assign diff     = row_index_i - prev_r;
  assign bit_set  = have_r && (row_index_i > prev_r);
  assign big_step = bit_set && (|diff[INDEX_BITS-1:1]);

  // insert the bit into the open word
  assign acc_a     = acc_r | (WORD_BITS'(bit_set) << pos_r);
  assign cnt_a     = cnt_r + CNT_BITS'(bit_set);
  assign gap_a     = gap_r | big_step;
  assign word_full = have_r && (pos_r == POS_BITS'(WORD_BITS - 1));

  // word state after a possible full-word close
  always_comb begin
    if (word_full) begin
      acc_b  = '0;
      cnt_b  = '0;
      gap_b  = 1'b0;
      pos_b  = '0;
      wnum_b = wnum_r + 1'b1;
      rank_b = rank_r + RANK_BITS'(cnt_a);
    end else begin
      acc_b  = acc_a;
      cnt_b  = cnt_a;
      gap_b  = gap_a;
      pos_b  = have_r ? pos_r + 1'b1 : pos_r;
      wnum_b = wnum_r;
      rank_b = rank_r;
    end
  end

  // candidate results
  always_comb begin
    res_full.bit_word    = acc_a;
    res_full.rank_before = rank_r;
    res_full.word_number = wnum_r;
    res_full.gap_seen    = gap_a;
    res_full.end_of_run  = 1'b0;
    res_last.bit_word    = acc_b;
    res_last.rank_before = rank_b;
    res_last.word_number = wnum_b;
    res_last.gap_seen    = gap_b;
    res_last.end_of_run  = 1'b1;
  end

  // results toward the queue
  always_comb begin
    push_o.num  = 2'd0;
    push_o.res0 = word_full ? res_full : res_last;
    push_o.res1 = res_last;
    if (take_i) begin
      push_o.num = {1'b0, word_full} + {1'b0, is_final_i};
    end
  end

  // next stream state
  always_comb begin
    prev_nxt = prev_r;
    have_nxt = have_r;
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    wnum_nxt = wnum_r;
    rank_nxt = rank_r;
    gap_nxt  = gap_r;
    if (take_i) begin
      if (is_final_i) begin
        prev_nxt = '0;
        have_nxt = 1'b0;
        acc_nxt  = '0;
        pos_nxt  = '0;
        cnt_nxt  = '0;
        wnum_nxt = '0;
        rank_nxt = '0;
        gap_nxt  = 1'b0;
      end else begin
        prev_nxt = row_index_i;
        have_nxt = 1'b1;
        acc_nxt  = acc_b;
        pos_nxt  = pos_b;
        cnt_nxt  = cnt_b;
        wnum_nxt = wnum_b;
        rank_nxt = rank_b;
        gap_nxt  = gap_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
      acc_r  <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
      wnum_r <= '0;
      rank_r <= '0;
      gap_r  <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      have_r <= have_nxt;
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      wnum_r <= wnum_nxt;
      rank_r <= rank_nxt;
      gap_r  <= gap_nxt;
    end
  end

  assign stat_o.have_prev = have_r;
  assign stat_o.bit_pos   = pos_r;

endmodule

[sv/rie_queue.sv]
`timescale 1ns / 1ps
// short result queue between front and back; takes up to two words a cycle
// and hands out one; depends on rie_pkg
module rie_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rie_pkg::push_t                push_i,
  output logic                          room_o,
  output logic                          head_valid_o,
  output rie_pkg::word_res_t            head_o,
  input  logic                          pop_i,
  output logic [rie_pkg::QCNT_BITS-1:0] count_o
);
  import rie_pkg::*;

  word_res_t             entry_r [QDEPTH];
  logic [QPTR_BITS-1:0]  head_r, head_nxt;
  logic [QPTR_BITS-1:0]  tail_r, tail_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                  do_pop;
  logic [QPTR_BITS-1:0]  tail_p1;

  assign do_pop  = pop_i && (cnt_r != '0);
  assign tail_p1 = tail_r + 1'b1;

  // pointer and fill bookkeeping
  always_comb begin
    head_nxt = do_pop ? head_r + 1'b1 : head_r;
    tail_nxt = tail_r + QPTR_BITS'(push_i.num);
    cnt_nxt  = cnt_r + QCNT_BITS'(push_i.num) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push_i.num != 2'd0) begin
      entry_r[tail_r] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      entry_r[tail_p1] <= push_i.res1;
    end
  end

  assign room_o       = (cnt_r <= QCNT_BITS'(QDEPTH - 2));
  assign head_valid_o = (cnt_r != '0);
  assign head_o       = entry_r[head_r];
  assign count_o      = cnt_r;

endmodule

[sv/rie_back.sv]
`timescale 1ns / 1ps
// back end: output register that drains the queue onto the result channel
// depends on rie_pkg and rie_out_if
module rie_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid_i,
  input  rie_pkg::word_res_t head_i,
  output logic               pop_o,
  rie_out_if.source          out_ch
);
  import rie_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  word_res_t out_res_r;
  logic      load;

  // load a new word when the register is empty or being taken
  assign load          = !out_valid_r || out_ch.ready;
  assign pop_o         = load && head_valid_i;
  assign out_valid_nxt = load ? head_valid_i : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      out_res_r <= head_i;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bit_word    = out_res_r.bit_word;
  assign out_ch.rank_before = out_res_r.rank_before;
  assign out_ch.word_number = out_res_r.word_number;
  assign out_ch.gap_seen    = out_res_r.gap_seen;
  assign out_ch.end_of_run  = out_res_r.end_of_run;

endmodule
